### hw/rtl/lcdns_pkg.sv
// Shared types, command codes and constant tables for the LCD nibble sequencer.
package lcdns_pkg;

  // Request command codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_GOTO   = 3'd3;
  localparam logic [2:0] CMD_NUMBER = 3'd4;
  localparam logic [2:0] CMD_GLYPH  = 3'd5;

  // Largest digit count printed for a number
  localparam int unsigned NUMBER_DIGITS = 3;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] CGRAM_SET     = 8'h40;
  localparam logic [7:0] DDRAM_SET     = 8'h80;
  localparam logic [3:0] INIT_STROBES  = 4'd9;
  localparam logic [4:0] POWER_UP_WAIT = 5'd31;

  // One enable strobe on the 4-bit bus
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [4:0] wait_before_ms;
    logic [1:0] high_ms;
    logic [1:0] low_ms;
    logic       last;
  } strobe_t;

  // Power-up nibbles: function set (third repaired to 8), display on, clear, entry mode
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd0:    nib = 4'h2;
      4'd1:    nib = 4'h2;
      4'd2:    nib = 4'h8;
      4'd3:    nib = 4'h0;
      4'd4:    nib = 4'hC;
      4'd5:    nib = 4'h0;
      4'd6:    nib = 4'h1;
      4'd7:    nib = 4'h0;
      4'd8:    nib = 4'h7;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

  // DDRAM start address of each display line
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0: base = 8'h80;
      2'd1: base = 8'hC0;
      2'd2: base = 8'h94;
      2'd3: base = 8'hD4;
    endcase
    return base;
  endfunction

endpackage

### hw/rtl/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD 4-bit nibble sequencer.
// The first strobe of a request passes through the request register and then the output register before it is shown.
// Throughput: one strobe per cycle while the consumer does not stall; a request has 2, 4, 6 or 9
//   strobes, and a request that yields no strobe leaves the block free for the next request.
// The next request is taken in the cycle its predecessor's last strobe moves out.
// Reset (rst, synchronous, active high) empties the request and output registers.
module char_lcd_nibble_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  // Request channel
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [2:0] cmd,
  input  logic [7:0] value,
  input  logic [1:0] row,
  input  logic [5:0] column,
  // Strobe channel, one item per enable pulse
  output logic       strobe_valid,
  input  logic       strobe_ready,
  output logic       rs,
  output logic [3:0] nibble,
  output logic [4:0] wait_before_ms,
  output logic [1:0] high_ms,
  output logic [1:0] low_ms,
  output logic       last
);

  logic               st_valid;
  logic               st_ready;
  lcdns_pkg::strobe_t st;
  lcdns_pkg::strobe_t strobe;

  // Hold the request, decode it into bytes and step through its strobes
  lcdns_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .value     (value),
    .row       (row),
    .column    (column),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st        (st)
  );

  // Register each strobe on its way out; a stalled consumer holds the sequencing
  // once this one-item slot is full
  lcdns_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st           (st),
    .strobe_valid (strobe_valid),
    .strobe_ready (strobe_ready),
    .strobe       (strobe)
  );

  // Break the strobe out onto its field ports
  assign rs             = strobe.rs;
  assign nibble         = strobe.nibble;
  assign wait_before_ms = strobe.wait_before_ms;
  assign high_ms        = strobe.high_ms;
  assign low_ms         = strobe.low_ms;
  assign last           = strobe.last;

endmodule

### hw/rtl/lcdns_front.sv
// Request register, decode into bytes and strobe sequencing.
module lcdns_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [2:0]          cmd,
  input  logic [7:0]          value,
  input  logic [1:0]          row,
  input  logic [5:0]          column,
  output logic                st_valid,
  input  logic                st_ready,
  output lcdns_pkg::strobe_t  st
);

  // Held request
  logic       busy;
  logic [3:0] idx;
  logic [3:0] count;
  logic       is_init;
  logic       rs_q;
  logic [1:0] tail_low;
  logic [7:0] byte0, byte1, byte2;

  // Decode of the incoming request
  logic [3:0] count_d;
  logic       is_init_d;
  logic       rs_d;
  logic [1:0] tail_low_d;
  logic [7:0] byte0_d, byte1_d, byte2_d;
  logic [1:0] hund;
  logic [6:0] rem;
  logic [13:0] tens_prod;
  logic [3:0] tens, units;
  logic [7:0] addr;

  logic       accept, fire, at_last;
  logic [7:0] cur_byte;

  assign at_last   = (idx == count - 4'd1);
  assign fire      = busy && st_ready;
  assign req_ready = !busy || (st_ready && at_last);
  assign accept    = req_valid && req_ready;
  assign st_valid  = busy;

  // Split 0..255 into decimal digits: compare for hundreds, reciprocal for tens
  always_comb begin
    if (value >= 8'd200) begin
      hund = 2'd2;
    end else if (value >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem       = 7'(value - 8'(hund) * 8'd100);
    tens_prod = 14'(rem) * 14'd103;
    tens      = tens_prod[13:10];
    units     = 4'(rem - 7'(tens) * 7'd10);
  end

  always_comb begin
    addr       = lcdns_pkg::row_base(row) + 8'(column);
    count_d    = 4'd2;
    is_init_d  = 1'b0;
    rs_d       = 1'b0;
    tail_low_d = 2'd1;
    byte0_d    = value;
    byte1_d    = 8'h00;
    byte2_d    = 8'h00;
    unique case (cmd)
      lcdns_pkg::CMD_INIT: begin
        count_d   = lcdns_pkg::INIT_STROBES;
        is_init_d = 1'b1;
      end
      lcdns_pkg::CMD_BYTE: begin
        tail_low_d = 2'd2;
      end
      lcdns_pkg::CMD_DATA: begin
        rs_d = 1'b1;
      end
      lcdns_pkg::CMD_GOTO: begin
        byte0_d = addr | lcdns_pkg::DDRAM_SET;
      end
      lcdns_pkg::CMD_NUMBER: begin
        rs_d = 1'b1;
        // Most significant digit goes first; no leading zeros
        if (value >= 8'd100) begin
          count_d = 4'd6;
          byte0_d = lcdns_pkg::ASCII_ZERO + 8'(hund);
          byte1_d = lcdns_pkg::ASCII_ZERO + 8'(tens);
          byte2_d = lcdns_pkg::ASCII_ZERO + 8'(units);
        end else if (value >= 8'd10) begin
          count_d = 4'd4;
          byte0_d = lcdns_pkg::ASCII_ZERO + 8'(tens);
          byte1_d = lcdns_pkg::ASCII_ZERO + 8'(units);
        end else begin
          byte0_d = lcdns_pkg::ASCII_ZERO + 8'(units);
        end
      end
      lcdns_pkg::CMD_GLYPH: begin
        byte0_d = lcdns_pkg::CGRAM_SET | {2'b00, value[2:0], 3'b000};
      end
      default: begin
        count_d = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (accept) begin
      busy <= (count_d != 4'd0);
      idx  <= 4'd0;
    end else if (fire) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count    <= count_d;
      is_init  <= is_init_d;
      rs_q     <= rs_d;
      tail_low <= tail_low_d;
      byte0    <= byte0_d;
      byte1    <= byte1_d;
      byte2    <= byte2_d;
    end
  end

  // Strobe for the current index
  always_comb begin
    unique case (idx[2:1])
      2'd0:    cur_byte = byte0;
      2'd1:    cur_byte = byte1;
      default: cur_byte = byte2;
    endcase
    st.last = at_last;
    if (is_init) begin
      st.rs             = 1'b0;
      st.nibble         = lcdns_pkg::init_nibble(idx);
      st.wait_before_ms = (idx == 4'd0) ? lcdns_pkg::POWER_UP_WAIT : 5'd0;
      st.high_ms        = 2'd2;
      st.low_ms         = 2'd2;
    end else begin
      st.rs             = rs_q;
      st.nibble         = idx[0] ? cur_byte[3:0] : cur_byte[7:4];
      st.wait_before_ms = 5'd0;
      st.high_ms        = 2'd1;
      st.low_ms         = at_last ? tail_low : 2'd1;
    end
  end

endmodule

### hw/rtl/lcdns_out_stage.sv
// Output register for strobes, decoupling the result channel from sequencing.
module lcdns_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                st_valid,
  output logic                st_ready,
  input  lcdns_pkg::strobe_t  st,
  output logic                strobe_valid,
  input  logic                strobe_ready,
  output lcdns_pkg::strobe_t  strobe
);

  assign st_ready = !strobe_valid || strobe_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_valid <= 1'b0;
    end else if (st_ready) begin
      strobe_valid <= st_valid;
    end
  end

  // Load when the slot is free or being drained
  always_ff @(posedge clk) begin
    if (st_ready && st_valid) begin
      strobe <= st;
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the character LCD 4-bit nibble sequencer.
`timescale 1ns / 100ps

module tb_top;

  // Command codes the block ignores: no strobe comes out for either
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_REQUESTS = 75;

  // One pending request; hold_for_drain makes the sender wait until every
  // expected strobe has come out before offering it
  typedef struct {
    logic [2:0] cmd;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] column;
    bit         hold_for_drain;
  } lcd_request_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  logic [2:0] cmd = '0;
  logic [7:0] value = '0;
  logic [1:0] row = '0;
  logic [5:0] column = '0;
  logic       strobe_valid;
  logic       strobe_ready = 1'b0;
  logic       rs;
  logic [3:0] nibble;
  logic [4:0] wait_before_ms;
  logic [1:0] high_ms;
  logic [1:0] low_ms;
  logic       last;

  lcd_request_t       request_q[$];   // items still to be offered
  lcdns_pkg::strobe_t strobes_due[$];  // strobes predicted but not yet seen
  lcd_request_t       on_bus;          // item currently offered on the request side
  int                 fail_count = 0;
  int                 offered = 0;
  int                 accepted = 0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 stall_mode = 0;
  int                 stall_left = 0;

  char_lcd_nibble_sequencer_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .cmd            (cmd),
    .value          (value),
    .row            (row),
    .column         (column),
    .strobe_valid   (strobe_valid),
    .strobe_ready   (strobe_ready),
    .rs             (rs),
    .nibble         (nibble),
    .wait_before_ms (wait_before_ms),
    .high_ms        (high_ms),
    .low_ms         (low_ms),
    .last           (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Strobe predictor
  // ---------------------------------------------------------------------

  // Append one strobe; the caller flags the final one of the request
  function automatic void add_strobe(input logic sel, input logic [3:0] nib,
                                     input logic [4:0] pre_ms, input logic [1:0] on_ms,
                                     input logic [1:0] off_ms);
    lcdns_pkg::strobe_t s;
    s.rs             = sel;
    s.nibble         = nib;
    s.wait_before_ms = pre_ms;
    s.high_ms        = on_ms;
    s.low_ms         = off_ms;
    s.last           = 1'b0;
    strobes_due.push_back(s);
  endfunction

  // Bytes go out high nibble first; only the low half's off time varies
  function automatic void add_byte(input logic sel, input logic [7:0] b,
                                   input logic [1:0] tail_ms);
    add_strobe(sel, b[7:4], 5'd0, 2'd1, 2'd1);
    add_strobe(sel, b[3:0], 5'd0, 2'd1, tail_ms);
  endfunction

  // Expand one accepted request into the strobes it must produce
  function automatic void expand_request(input lcd_request_t r);
    logic [3:0] power_up[9];
    logic [7:0] base[4];
    logic [7:0] addr;
    logic [3:0] digit[lcdns_pkg::NUMBER_DIGITS];
    int         ndig;
    int         v;
    int         start;
    power_up = '{4'h2, 4'h2, 4'h8, 4'h0, 4'hC, 4'h0, 4'h1, 4'h0, 4'h7};
    base     = '{8'h80, 8'hC0, 8'h94, 8'hD4};
    start    = strobes_due.size();
    case (r.cmd)
      lcdns_pkg::CMD_INIT: begin
        // Long power-up wait on the first strobe only, slow timing throughout
        for (int i = 0; i < 9; i++)
          add_strobe(1'b0, power_up[i], (i == 0) ? lcdns_pkg::POWER_UP_WAIT : 5'd0,
                     2'd2, 2'd2);
      end
      lcdns_pkg::CMD_BYTE: add_byte(1'b0, r.value, 2'd2);
      lcdns_pkg::CMD_DATA: add_byte(1'b1, r.value, 2'd1);
      lcdns_pkg::CMD_GOTO: begin
        // Address wraps at 8 bits; D7 forced high on the upper nibble
        addr = base[r.row] + {2'b00, r.column};
        add_strobe(1'b0, {1'b1, addr[6:4]}, 5'd0, 2'd1, 2'd1);
        add_strobe(1'b0, addr[3:0], 5'd0, 2'd1, 2'd1);
      end
      lcdns_pkg::CMD_NUMBER: begin
        // Collect digits least significant first, drop leading zeros
        v    = r.value;
        ndig = 0;
        if (v == 0) begin
          digit[0] = 4'd0;
          ndig     = 1;
        end else begin
          while (v != 0 && ndig < lcdns_pkg::NUMBER_DIGITS) begin
            digit[ndig] = 4'(v % 10);
            v           = v / 10;
            ndig++;
          end
        end
        for (int i = ndig - 1; i >= 0; i--)
          add_byte(1'b1, lcdns_pkg::ASCII_ZERO + {4'd0, digit[i]}, 2'd1);
      end
      lcdns_pkg::CMD_GLYPH: begin
        // CGRAM address is block * 8; only the low six bits reach the bus
        addr = {r.value[4:0], 3'b000};
        add_strobe(1'b0, {2'b01, addr[5:4]}, 5'd0, 2'd1, 2'd1);
        add_strobe(1'b0, addr[3:0], 5'd0, 2'd1, 2'd1);
      end
      default: ;
    endcase
    if (strobes_due.size() > start)
      strobes_due[strobes_due.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endtask

  // Monitor: take each accepted strobe and compare against the oldest prediction
  always @(posedge clk) begin
    lcdns_pkg::strobe_t want;
    if (!rst && strobe_valid && strobe_ready) begin
      if (strobes_due.size() == 0) begin
        report_mismatch("unexpected strobe, nibble", 32'hFFFF_FFFF, {28'd0, nibble});
      end else begin
        want = strobes_due.pop_front();
        if (want.rs !== rs) report_mismatch("rs", 32'(want.rs), 32'(rs));
        if (want.nibble !== nibble)
          report_mismatch("nibble", 32'(want.nibble), 32'(nibble));
        if (want.wait_before_ms !== wait_before_ms)
          report_mismatch("wait_before_ms", 32'(want.wait_before_ms),
                          32'(wait_before_ms));
        if (want.high_ms !== high_ms)
          report_mismatch("high_ms", 32'(want.high_ms), 32'(high_ms));
        if (want.low_ms !== low_ms)
          report_mismatch("low_ms", 32'(want.low_ms), 32'(low_ms));
        if (want.last !== last) report_mismatch("last", 32'(want.last), 32'(last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    bit launch;
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      // Predict at the edge where the item is taken
      if (req_valid && req_ready) begin
        expand_request(on_bus);
        accepted++;
      end
      if (!req_valid || req_ready) begin
        launch = 1'b0;
        if (gap_left > 0)
          gap_left--;
        else if (request_q.size() > 0 &&
                 (!request_q[0].hold_for_drain || strobes_due.size() == 0))
          launch = 1'b1;
        if (launch) begin
          on_bus    = request_q.pop_front();
          cmd       <= on_bus.cmd;
          value     <= on_bus.value;
          row       <= on_bus.row;
          column    <= on_bus.column;
          req_valid <= 1'b1;
          offered++;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Strobe receiver: stall pattern switches between free, choppy and starved
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      strobe_ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 40);
      end
      stall_left--;
      case (stall_mode)
        0:       strobe_ready <= 1'b1;
        1:       strobe_ready <= $urandom_range(0, 1);
        default: strobe_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic void add_request(input logic [2:0] c, input logic [7:0] v,
                                      input logic [1:0] r, input logic [5:0] col,
                                      input bit drain);
    lcd_request_t q;
    q.cmd            = c;
    q.value          = v;
    q.row            = r;
    q.column         = col;
    q.hold_for_drain = drain;
    request_q.push_back(q);
  endfunction

  function automatic logic [5:0] pick_column();
    // Mostly legal columns, now and then past the line end to force a wrap
    if ($urandom_range(0, 7) == 0)
      return 6'($urandom_range(40, 63));
    return 6'($urandom_range(0, 39));
  endfunction

  initial begin
    int          done;
    int          pick;
    logic [7:0]  block;

    // Directed: extremes of every field, each command, the special cases
    add_request(lcdns_pkg::CMD_INIT,   8'h00, 2'd0, 6'd0,  1'b0);
    add_request(lcdns_pkg::CMD_BYTE,   8'h00, 2'd3, 6'd63, 1'b0);
    add_request(lcdns_pkg::CMD_BYTE,   8'hFF, 2'd0, 6'd0,  1'b0);
    add_request(lcdns_pkg::CMD_DATA,   8'h00, 2'd0, 6'd0,  1'b0);
    add_request(lcdns_pkg::CMD_DATA,   8'hFF, 2'd0, 6'd0,  1'b0);
    add_request(lcdns_pkg::CMD_GOTO,   8'h00, 2'd0, 6'd0,  1'b0);
    add_request(lcdns_pkg::CMD_GOTO,   8'hFF, 2'd1, 6'd39, 1'b0);
    add_request(lcdns_pkg::CMD_GOTO,   8'h00, 2'd2, 6'd19, 1'b0);
    add_request(lcdns_pkg::CMD_GOTO,   8'h00, 2'd3, 6'd63, 1'b0);   // address wraps past 0xFF
    add_request(lcdns_pkg::CMD_NUMBER, 8'd0,   2'd0, 6'd0, 1'b1);   // single '0'
    add_request(lcdns_pkg::CMD_NUMBER, 8'd9,   2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_NUMBER, 8'd10,  2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_NUMBER, 8'd99,  2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_NUMBER, 8'd100, 2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_NUMBER, 8'd255, 2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_GLYPH,  8'd0,   2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_GLYPH,  8'd7,   2'd0, 6'd0, 1'b0);
    add_request(lcdns_pkg::CMD_GLYPH,  8'd8,   2'd0, 6'd0, 1'b0);   // block wraps modulo 8
    add_request(lcdns_pkg::CMD_GLYPH,  8'hFF,  2'd0, 6'd0, 1'b0);
    add_request(CMD_SPARE_A, 8'hFF, 2'd3, 6'd63, 1'b0);  // no strobe
    add_request(CMD_SPARE_B, 8'h00, 2'd0, 6'd0,  1'b0);  // no strobe
    add_request(lcdns_pkg::CMD_DATA,   8'h5A, 2'd0, 6'd0,  1'b0);

    // Random: custom glyph sequences with random content, mixed with loose requests
    done = 0;
    while (done < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        // Block select, eight rows of pixels, goto, then print the glyph
        block = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) block = block + 8'(8 * $urandom_range(1, 31));
        add_request(lcdns_pkg::CMD_GLYPH, block, 2'($urandom), pick_column(), pick == 0);
        for (int i = 0; i < 8; i++)
          add_request(lcdns_pkg::CMD_DATA, 8'($urandom), 2'($urandom), pick_column(),
                      1'b0);
        add_request(lcdns_pkg::CMD_GOTO, 8'($urandom), 2'($urandom), pick_column(), 1'b0);
        add_request(lcdns_pkg::CMD_DATA, {5'd0, block[2:0]}, 2'($urandom), pick_column(),
                    1'b0);
        done += 11;
      end else if (pick == 18) begin
        // Ignored commands: noise only, not counted
        add_request(($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B,
                    8'($urandom), 2'($urandom), pick_column(), 1'b0);
      end else begin
        case ($urandom_range(0, 5))
          0: add_request(lcdns_pkg::CMD_INIT, 8'($urandom), 2'($urandom),
                         pick_column(), 1'b0);
          1: add_request(lcdns_pkg::CMD_BYTE, 8'($urandom), 2'($urandom),
                         pick_column(), 1'b0);
          2: add_request(lcdns_pkg::CMD_DATA, 8'($urandom), 2'($urandom),
                         pick_column(), 1'b0);
          3: add_request(lcdns_pkg::CMD_GOTO, 8'($urandom), 2'($urandom),
                         pick_column(), 1'b0);
          4: add_request(lcdns_pkg::CMD_NUMBER, ($urandom_range(0, 2) == 0) ?
                         8'($urandom_range(0, 12)) : 8'($urandom),
                         2'($urandom), pick_column(), 1'b0);
          default: add_request(lcdns_pkg::CMD_GLYPH, 8'($urandom), 2'($urandom),
                               pick_column(), 1'b0);
        endcase
        done++;
      end
    end

    // Hold reset at the start, then release it at a clock edge
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge to stay clear of the driver's updates
    while (request_q.size() != 0 || accepted != offered) @(negedge clk);
    while (strobes_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
